// ===== sv/bitmap_first_free_allocator_macros.svh =====
// ----------------------------------------------------------------------------
// Bitmap allocator assertion macros
// Concurrent assertion wrappers clocked on clk, disabled during rst_n low.
// ----------------------------------------------------------------------------
`ifndef BITMAP_FIRST_FREE_ALLOCATOR_MACROS_SVH
`define BITMAP_FIRST_FREE_ALLOCATOR_MACROS_SVH

// same-cycle implication
`define BFFA_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define BFFA_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== sv/bffa_pkg.sv =====
// ----------------------------------------------------------------------------
// Bitmap allocator package
// Field widths, function and status codes, sequencer states, shared helpers.
// ----------------------------------------------------------------------------
`default_nettype none

package bffa_pkg;

    localparam int FUNC_W        = 2;
    localparam int ADDR_W        = 10;
    localparam int DATA_W        = 32;
    localparam int SLOT_W        = 16;
    localparam int STAT_W        = 2;
    localparam int CFG_IDX_W     = 1;
    localparam int CFG_DATA_W    = 16;
    localparam int MAX_WORD_BITS = 64;
    localparam int MAX_BIT_W     = 6;

    localparam logic [FUNC_W-1:0] FN_LOAD  = 2'd0;
    localparam logic [FUNC_W-1:0] FN_ALLOC = 2'd1;
    localparam logic [FUNC_W-1:0] FN_MARK  = 2'd2;

    localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
    localparam logic [STAT_W-1:0] ST_FULL  = 2'd1;
    localparam logic [STAT_W-1:0] ST_RANGE = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_SLOT_LIMIT = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_INDEX_BASE = 1'b1;

    localparam logic [CFG_DATA_W-1:0] SLOT_LIMIT_RST = 16'd32768;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_SCAN,
        S_MDIV,
        S_MRD,
        S_MWR,
        S_RESULT
    } bffa_state_t;

    typedef struct packed {
        logic busy;
        logic done;
    } bffa_div_stat_t;

    function automatic logic [MAX_BIT_W-1:0] bffa_ffs(input logic [MAX_WORD_BITS-1:0] v);
        logic [MAX_WORD_BITS-1:0] low;
        logic [MAX_BIT_W-1:0]     idx;
        low = v & (~v + {{(MAX_WORD_BITS-1){1'b0}}, 1'b1});
        idx = '0;
        for (int i = 0; i < MAX_WORD_BITS; i++)
        begin
            if (low[MAX_BIT_W'(i)])
            begin
                idx = idx | MAX_BIT_W'(i);
            end
        end
        return idx;
    endfunction

endpackage

`default_nettype wire

// ===== sv/bffa_req_if.sv =====
// ----------------------------------------------------------------------------
// Bitmap allocator request channel
// Valid/ready channel carrying one operation per transaction.
// ----------------------------------------------------------------------------
`default_nettype none

interface bffa_req_if;
    import bffa_pkg::*;

    logic              valid;
    logic              ready;
    logic [FUNC_W-1:0] func;
    logic [ADDR_W-1:0] word_addr;
    logic [DATA_W-1:0] word_data;
    logic [SLOT_W-1:0] slot_index;

    modport source (output valid, output func, output word_addr, output word_data,
                    output slot_index, input ready);
    modport sink   (input valid, input func, input word_addr, input word_data,
                    input slot_index, output ready);
endinterface

`default_nettype wire

// ===== sv/bffa_rsp_if.sv =====
// ----------------------------------------------------------------------------
// Bitmap allocator response channel
// Valid/ready channel carrying one status/slot result per transaction.
// ----------------------------------------------------------------------------
`default_nettype none

interface bffa_rsp_if;
    import bffa_pkg::*;

    logic              valid;
    logic              ready;
    logic [STAT_W-1:0] status;
    logic [SLOT_W-1:0] slot_found;

    modport source (output valid, output status, output slot_found, input ready);
    modport sink   (input valid, input status, input slot_found, output ready);
endinterface

`default_nettype wire

// ===== sv/bffa_ram.sv =====
// ----------------------------------------------------------------------------
// Generic single-write, single-read RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
`default_nettype none

module bffa_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  wire logic                                  clk,
    input  wire logic                                  we,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  wire logic [WIDTH-1:0]                      wdata,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic      [WIDTH-1:0]                      rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

`default_nettype wire

// ===== sv/bffa_div.sv =====
// ----------------------------------------------------------------------------
// Divider by a constant
// Reciprocal multiplication, quotient then remainder registered; splits a slot
// number into word address and bit position.
// ----------------------------------------------------------------------------
`default_nettype none

module bffa_div #(
    parameter int DIVISOR = 32,
    parameter int IN_W    = 16
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         start,
    input  wire logic [IN_W-1:0]              dividend,
    output bffa_pkg::bffa_div_stat_t          stat,
    output logic      [IN_W-1:0]              quotient,
    output logic      [$clog2(DIVISOR)-1:0]   remainder
);
    import bffa_pkg::*;

    localparam int     RW    = $clog2(DIVISOR);
    localparam int     MW    = IN_W + 2;
    localparam int     PW    = IN_W + MW;
    localparam longint RECIP = ((longint'(1) << (IN_W + RW)) / DIVISOR) + 1;

    logic            busy_reg;
    logic            done_reg;
    logic [IN_W-1:0] x_reg;
    logic [IN_W-1:0] q_reg;
    logic [RW-1:0]   rem_reg;
    logic [PW-1:0]   prod;
    logic [IN_W-1:0] q_est;
    logic [IN_W-1:0] q_times_d;
    logic [IN_W-1:0] diff;

    always_comb
    begin
        prod      = PW'(dividend) * PW'(RECIP);
        q_est     = IN_W'(prod >> (IN_W + RW));
        q_times_d = q_reg * IN_W'(DIVISOR);
        diff      = x_reg - q_times_d;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= start;
            done_reg <= busy_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            x_reg <= dividend;
            q_reg <= q_est;
        end
        if (busy_reg)
        begin
            rem_reg <= diff[RW-1:0];
        end
    end

    assign stat      = '{busy: busy_reg, done: done_reg};
    assign quotient  = q_reg;
    assign remainder = rem_reg;
endmodule

`default_nettype wire

// ===== sv/bitmap_first_free_allocator.sv =====
// ----------------------------------------------------------------------------
// Bitmap first-free slot allocator
// Used/free bitmap in a word-wide RAM with load, allocate and mark operations.
// Usage:
//   req carries one operation per transaction: load a bitmap word, allocate
//   the lowest free slot below slot_limit, or mark a slot used. rsp returns
//   one status/slot_found result per request, in order.
//   cfg_wr_en/cfg_index/cfg_data write slot_limit (index 0) and index_base
//   (index 1); write only while no request is in flight.
//   Steps from acceptance to rsp.valid: load, unused codes and range errors
//   go straight to the result register; mark runs a reciprocal divide for
//   word/bit, then a read and a write; allocate runs the scan, which reads
//   one bitmap word per cycle from the single RAM read port.
//   One request is in work at a time; req.ready is high only when idle.
//   After reset a clearing pass writes every bitmap word to zero, with
//   req.ready low; configuration writes are taken as usual.
//   A result waits in the output register while rsp.ready is low; the
//   next request is still accepted, and its result holds until the output
//   register frees up.
// ----------------------------------------------------------------------------
`default_nettype none

module bitmap_first_free_allocator #(
    parameter int MAP_BITS  = 32768,
    parameter int WORD_BITS = 32
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    bffa_req_if.sink                               req,
    bffa_rsp_if.source                             rsp,
    input  wire logic                              cfg_wr_en,
    input  wire logic [bffa_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [bffa_pkg::CFG_DATA_W-1:0]   cfg_data
);
    import bffa_pkg::*;

    `include "bitmap_first_free_allocator_macros.svh"

    localparam int NWORDS = (MAP_BITS + WORD_BITS - 1) / WORD_BITS;
    localparam int AW     = NWORDS > 1 ? $clog2(NWORDS) : 1;
    localparam int BIW    = $clog2(WORD_BITS);
    localparam int LW     = $clog2(MAP_BITS + WORD_BITS + 1);
    localparam int CW     = LW > SLOT_W ? LW : SLOT_W;

    bffa_state_t state_reg, state_next;

    logic [CFG_DATA_W-1:0] slot_limit_reg;
    logic                  index_base_reg;

    logic [AW-1:0]     clr_ptr_reg,    clr_ptr_next;
    logic [AW-1:0]     issue_ptr_reg,  issue_ptr_next;
    logic [CW-1:0]     issue_base_reg, issue_base_next;
    logic [AW-1:0]     eval_addr_reg,  eval_addr_next;
    logic [CW-1:0]     eval_base_reg,  eval_base_next;
    logic              pend_reg,       pend_next;
    logic [STAT_W-1:0] res_status_reg, res_status_next;
    logic [SLOT_W-1:0] res_found_reg,  res_found_next;
    logic              out_valid_reg,  out_valid_next;
    logic [STAT_W-1:0] out_status_reg, out_status_next;
    logic [SLOT_W-1:0] out_found_reg,  out_found_next;

    logic                 ram_we;
    logic [AW-1:0]        ram_waddr;
    logic [WORD_BITS-1:0] ram_wdata;
    logic [AW-1:0]        ram_raddr;
    logic [WORD_BITS-1:0] ram_rdata;

    logic              div_start;
    bffa_div_stat_t    div_stat;
    logic [SLOT_W-1:0] div_quot;
    logic [BIW-1:0]    div_rem;

    logic                 acc;
    logic [CW-1:0]        lim;
    logic [WORD_BITS-1:0] freeb;
    logic [BIW-1:0]       bit_pos;
    logic [CW-1:0]        eval_slot;
    logic                 hit;
    logic                 can_issue;
    logic                 mark_low;
    logic [SLOT_W-1:0]    mslot;
    logic                 mark_high;
    logic                 load_ok;

    bffa_ram #(
        .WIDTH (WORD_BITS),
        .DEPTH (NWORDS)
    ) u_map_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    bffa_div #(
        .DIVISOR (WORD_BITS),
        .IN_W    (SLOT_W)
    ) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .dividend  (mslot),
        .stat      (div_stat),
        .quotient  (div_quot),
        .remainder (div_rem)
    );

    assign acc       = req.valid && req.ready;
    assign req.ready = (state_reg == S_IDLE);

    assign lim = (CW'(slot_limit_reg) > CW'(MAP_BITS)) ? CW'(MAP_BITS) : CW'(slot_limit_reg);

    assign freeb     = ~ram_rdata;
    assign bit_pos   = BIW'(bffa_ffs(MAX_WORD_BITS'(freeb)));
    assign eval_slot = eval_base_reg + CW'(bit_pos);
    assign hit       = pend_reg && (|freeb) && (eval_slot < lim);
    assign can_issue = issue_base_reg < lim;

    assign mark_low  = req.slot_index < SLOT_W'(index_base_reg);
    assign mslot     = req.slot_index - SLOT_W'(index_base_reg);
    assign mark_high = CW'(mslot) >= lim;
    assign load_ok   = 32'(req.word_addr) < 32'(NWORDS);

    always_comb
    begin
        state_next      = state_reg;
        clr_ptr_next    = clr_ptr_reg;
        issue_ptr_next  = issue_ptr_reg;
        issue_base_next = issue_base_reg;
        eval_addr_next  = eval_addr_reg;
        eval_base_next  = eval_base_reg;
        pend_next       = pend_reg;
        res_status_next = res_status_reg;
        res_found_next  = res_found_reg;
        out_valid_next  = out_valid_reg && !rsp.ready;
        out_status_next = out_status_reg;
        out_found_next  = out_found_reg;
        ram_we          = 1'b0;
        ram_waddr       = '0;
        ram_wdata       = '0;
        ram_raddr       = issue_ptr_reg;
        div_start       = 1'b0;

        case (state_reg)
            S_CLEAR:
            begin
                ram_we       = 1'b1;
                ram_waddr    = clr_ptr_reg;
                clr_ptr_next = clr_ptr_reg + 1'b1;
                if (clr_ptr_reg == AW'(NWORDS - 1))
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (acc)
                begin
                    res_status_next = ST_OK;
                    res_found_next  = '0;
                    state_next      = S_RESULT;
                    case (req.func)
                        FN_LOAD:
                        begin
                            ram_we    = load_ok;
                            ram_waddr = AW'(req.word_addr);
                            ram_wdata = WORD_BITS'(req.word_data);
                        end
                        FN_ALLOC:
                        begin
                            issue_ptr_next  = '0;
                            issue_base_next = '0;
                            pend_next       = 1'b0;
                            state_next      = S_SCAN;
                        end
                        FN_MARK:
                        begin
                            if (mark_low || mark_high)
                            begin
                                res_status_next = ST_RANGE;
                            end
                            else
                            begin
                                div_start  = 1'b1;
                                state_next = S_MDIV;
                            end
                        end
                        default:
                        begin
                            state_next = S_RESULT;
                        end
                    endcase
                end
            end
            S_SCAN:
            begin
                if (hit)
                begin
                    ram_we         = 1'b1;
                    ram_waddr      = eval_addr_reg;
                    ram_wdata      = ram_rdata | (WORD_BITS'(1) << bit_pos);
                    res_found_next = SLOT_W'(eval_slot + CW'(index_base_reg));
                    pend_next      = 1'b0;
                    state_next     = S_RESULT;
                end
                else if (!can_issue)
                begin
                    res_status_next = ST_FULL;
                    pend_next       = 1'b0;
                    state_next      = S_RESULT;
                end
                else
                begin
                    issue_ptr_next  = issue_ptr_reg + 1'b1;
                    issue_base_next = issue_base_reg + CW'(WORD_BITS);
                    eval_addr_next  = issue_ptr_reg;
                    eval_base_next  = issue_base_reg;
                    pend_next       = 1'b1;
                end
            end
            S_MDIV:
            begin
                if (div_stat.done)
                begin
                    state_next = S_MRD;
                end
            end
            S_MRD:
            begin
                ram_raddr  = AW'(div_quot);
                state_next = S_MWR;
            end
            S_MWR:
            begin
                ram_we     = 1'b1;
                ram_waddr  = AW'(div_quot);
                ram_wdata  = ram_rdata | (WORD_BITS'(1) << div_rem);
                state_next = S_RESULT;
            end
            S_RESULT:
            begin
                if (!out_valid_reg || rsp.ready)
                begin
                    out_valid_next  = 1'b1;
                    out_status_next = res_status_reg;
                    out_found_next  = res_found_reg;
                    state_next      = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_CLEAR;
            clr_ptr_reg    <= '0;
            pend_reg       <= 1'b0;
            out_valid_reg  <= 1'b0;
            slot_limit_reg <= SLOT_LIMIT_RST;
            index_base_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_ptr_reg   <= clr_ptr_next;
            pend_reg      <= pend_next;
            out_valid_reg <= out_valid_next;
            if (cfg_wr_en)
            begin
                case (cfg_index)
                    CFG_SLOT_LIMIT: slot_limit_reg <= cfg_data;
                    CFG_INDEX_BASE: index_base_reg <= cfg_data[0];
                    default:        slot_limit_reg <= slot_limit_reg;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        issue_ptr_reg  <= issue_ptr_next;
        issue_base_reg <= issue_base_next;
        eval_addr_reg  <= eval_addr_next;
        eval_base_reg  <= eval_base_next;
        res_status_reg <= res_status_next;
        res_found_reg  <= res_found_next;
        out_status_reg <= out_status_next;
        out_found_reg  <= out_found_next;
    end

    assign rsp.valid      = out_valid_reg;
    assign rsp.status     = out_status_reg;
    assign rsp.slot_found = out_found_reg;

    `BFFA_ASSERT_NEXT(a_busy_after_accept, acc, !req.ready,
        "request accepted while previous one still in work")
    `BFFA_ASSERT_NOW(a_found_zero_on_error, rsp.valid && rsp.status != ST_OK,
        rsp.slot_found == '0, "nonzero slot reported with error status")
    `BFFA_ASSERT_NOW(a_scan_write_needs_data, state_reg == S_SCAN && ram_we,
        pend_reg, "scan write-back without a pending read word")
    `BFFA_ASSERT_NOW(a_div_only_in_mark, div_stat.busy || div_stat.done,
        state_reg == S_MDIV, "divider active outside mark sequence")
endmodule

`default_nettype wire
